FILE: rtl/table_waveform_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the table waveform generator
// Concurrent checks that are compiled away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TABLE_WAVEFORM_GENERATOR_ASSERT_SVH
`define TABLE_WAVEFORM_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define TWG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("table_waveform_generator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("table_waveform_generator assertion failed");

`else

`define TWG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TWG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/twg_pkg.sv
// ----------------------------------------------------------------------------
// twg_pkg
// Types, constants and the elaboration-time sine table builder for the
// table waveform generator.
// ----------------------------------------------------------------------------
package twg_pkg;

    localparam int STEPS_PER_PERIOD = 100;
    localparam int SAMPLE_BITS      = 12;

    localparam int TRI_SLOPE = 80;
    localparam int SAW_SLOPE = 40;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [6:0]  DUTY_RESET     = 7'd50;
    localparam logic [15:0] INTERVAL_RESET = 16'd2413;

    // Fixed-point format of the sine table builder.
    localparam int          Q_BITS    = 30;
    localparam logic [63:0] Q_ONE     = 64'd1 << Q_BITS;
    localparam logic [63:0] PI_Q      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_SQUARE   = 2'd3
    } t_wave_mode;

    typedef enum logic [1:0] {
        REG_WAVE_MODE = 2'd0,
        REG_DUTY      = 2'd1,
        REG_INTERVAL  = 2'd2
    } t_reg_index;

    // Sine table entry for an angle held in Q30. Only evaluated while the
    // design elaborates: a quadrant fold and a truncated Taylor series.
    function automatic logic [63:0] sine_code(input logic [63:0] angle,
                                              input logic [63:0] scale,
                                              input logic [63:0] full);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] v;
        logic        neg;
        x   = angle;
        neg = 1'b0;
        if (x >= PI_Q) begin
            x   = x - PI_Q;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q) begin
            x = (x > PI_Q) ? 64'd0 : PI_Q - x;
        end
        sum  = x;
        term = x;
        for (int k = 1; k <= 12; k++) begin
            term = (term * x) >> Q_BITS;
            term = (term * x) >> Q_BITS;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = (sum > term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        if (sum > Q_ONE) begin
            sum = Q_ONE;
        end
        v = neg ? (Q_ONE - sum) : (Q_ONE + sum);
        v = (v * scale) >> Q_BITS;
        return (v > full) ? full : v;
    endfunction

endpackage

FILE: rtl/twg_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces of the table waveform generator
// Tick input channel and sample output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface twg_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface twg_sample_if #(
    parameter int SAMPLE_BITS = twg_pkg::SAMPLE_BITS,
    parameter int PHASE_BITS  = $clog2(twg_pkg::STEPS_PER_PERIOD)
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [PHASE_BITS-1:0]  phase_step;
    logic                   period_start;

    modport source (output valid, output sample, output phase_step, output period_start,
                    input ready);
    modport sink (input valid, input sample, input phase_step, input period_start,
                  output ready);
endinterface

FILE: rtl/table_waveform_generator.sv
// ----------------------------------------------------------------------------
// table_waveform_generator
// Tick-driven DAC sample generator with sine, triangle, sawtooth and square.
// ----------------------------------------------------------------------------
// Usage:
//   i_tick_ch carries one timer tick per transfer (tick = 0 is an idle item).
//   Every tick_interval ticks the block sends one transfer on o_sample_ch:
//   the DAC code, the phase step it was taken at and a period start flag.
//   The phase runs 0 to STEPS_PER_PERIOD-1 and then wraps.
//   Registers on the APB port: wave_mode at 0x0, duty_percent at 0x4,
//   tick_interval at 0x8 (zero acts as one). Writes take effect at the
//   next sample; the tick count and phase are kept.
// Timing:
//   One tick is taken every cycle while i_tick_ch.ready is high. The tick
//   that causes a sample updates the counter and loads the sine table read
//   and the sample stage; the waveform select then feeds the output register.
//   The only throttle is the output register; when the receiver stalls, the
//   sample stage holds and i_tick_ch.ready drops once both are full.
// Reset (synchronous, active low): registers return to square wave, 50 percent
//   duty, interval 2413; tick count and phase clear; nothing is pending.
// ----------------------------------------------------------------------------
`include "table_waveform_generator_assert.svh"

module table_waveform_generator #(
    parameter int STEPS_PER_PERIOD = twg_pkg::STEPS_PER_PERIOD,
    parameter int SAMPLE_BITS      = twg_pkg::SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    twg_tick_if.sink                             i_tick_ch,
    twg_sample_if.source                         o_sample_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [twg_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [twg_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [twg_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    localparam int PHASE_BITS = $clog2(STEPS_PER_PERIOD);

    twg_pkg::t_wave_mode    r_wave_mode;
    logic [6:0]             r_duty;
    logic [15:0]            r_interval;
    logic [15:0]            r_tick_count;
    logic [PHASE_BITS-1:0]  r_phase;
    logic                   r_b_valid;
    logic [PHASE_BITS-1:0]  r_b_phase;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic [PHASE_BITS-1:0]  r_out_phase;
    logic                   r_out_start;

    logic [15:0]            n_tick_count;
    logic [PHASE_BITS-1:0]  n_phase;

    logic [15:0]            w_limit;
    logic [16:0]            w_count;
    logic                   w_emit;
    logic [PHASE_BITS-1:0]  w_index;
    logic                   w_tick_xfer;
    logic                   w_load;
    logic                   w_out_free;
    logic                   w_b_free;
    logic                   w_b_move;
    logic                   w_cfg_wr;
    logic [SAMPLE_BITS-1:0] w_sample;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= twg_pkg::WAVE_SQUARE;
            r_duty      <= twg_pkg::DUTY_RESET;
            r_interval  <= twg_pkg::INTERVAL_RESET;
        end else if (w_cfg_wr) begin
            unique case (twg_pkg::t_reg_index'(paddr[3:2]))
                twg_pkg::REG_WAVE_MODE: r_wave_mode <= twg_pkg::t_wave_mode'(pwdata[1:0]);
                twg_pkg::REG_DUTY:      r_duty      <= pwdata[6:0];
                twg_pkg::REG_INTERVAL:  r_interval  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (twg_pkg::t_reg_index'(paddr[3:2]))
            twg_pkg::REG_WAVE_MODE: prdata = twg_pkg::CFG_DATA_BITS'(r_wave_mode);
            twg_pkg::REG_DUTY:      prdata = twg_pkg::CFG_DATA_BITS'(r_duty);
            twg_pkg::REG_INTERVAL:  prdata = twg_pkg::CFG_DATA_BITS'(r_interval);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Tick counter and phase
    // ------------------------------------------------------------------
    assign w_out_free        = !r_out_valid || o_sample_ch.ready;
    assign w_b_move          = r_b_valid && w_out_free;
    assign w_b_free          = !r_b_valid || w_out_free;
    assign i_tick_ch.ready   = w_b_free;

    always_comb begin
        w_limit     = (r_interval == 16'd0) ? 16'd1 : r_interval;
        w_count     = {1'b0, r_tick_count} + 17'd1;
        w_emit      = (w_count >= {1'b0, w_limit});
        w_index     = ({1'b0, r_phase} < (PHASE_BITS + 1)'(STEPS_PER_PERIOD)) ? r_phase : '0;
        w_tick_xfer = i_tick_ch.valid && i_tick_ch.ready && i_tick_ch.tick;
        w_load      = w_tick_xfer && w_emit;

        n_tick_count = r_tick_count;
        n_phase      = r_phase;
        if (w_tick_xfer) begin
            if (w_emit) begin
                n_tick_count = '0;
                n_phase      = (w_index == PHASE_BITS'(STEPS_PER_PERIOD - 1)) ? '0
                                                                            : w_index + 1'b1;
            end else begin
                n_tick_count = w_count[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_phase      <= '0;
            r_b_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_tick_count <= n_tick_count;
            r_phase      <= n_phase;
            if (w_load) begin
                r_b_valid <= 1'b1;
            end else if (w_b_move) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_move) begin
                r_out_valid <= 1'b1;
            end else if (o_sample_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample stage and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_b_phase <= w_index;
        end
        if (w_b_move) begin
            r_out_sample <= w_sample;
            r_out_phase  <= r_b_phase;
            r_out_start  <= (r_b_phase == '0);
        end
    end

    twg_wave #(
        .STEPS_PER_PERIOD (STEPS_PER_PERIOD),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .PHASE_BITS       (PHASE_BITS)
    ) u_wave (
        .i_clk      (i_clk),
        .i_rd_en    (w_load),
        .i_rd_phase (w_index),
        .i_phase    (r_b_phase),
        .i_mode     (r_wave_mode),
        .i_duty     (r_duty),
        .o_sample   (w_sample)
    );

    assign o_sample_ch.valid        = r_out_valid;
    assign o_sample_ch.sample       = r_out_sample;
    assign o_sample_ch.phase_step   = r_out_phase;
    assign o_sample_ch.period_start = r_out_start;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The stored phase never leaves the period.
    `TWG_ASSERT_IMP(a_phase_range, i_clk, i_rst_n, 1'b1, {1'b0, r_phase} < (PHASE_BITS + 1)'(STEPS_PER_PERIOD))
    // A new sample never overwrites one that cannot move on.
    `TWG_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_load && r_b_valid, w_out_free)
    // A sample that leaves the sample stage lands in the output register.
    `TWG_ASSERT_NEXT(a_stage_to_out, i_clk, i_rst_n, w_b_move, r_out_valid && (r_out_start == (r_out_phase == '0)))

endmodule

FILE: rtl/twg_wave.sv
// ----------------------------------------------------------------------------
// twg_wave
// Sine table with a registered read port, and the per-mode sample selection
// for the phase held in the sample stage.
// ----------------------------------------------------------------------------
module twg_wave #(
    parameter int STEPS_PER_PERIOD = twg_pkg::STEPS_PER_PERIOD,
    parameter int SAMPLE_BITS      = twg_pkg::SAMPLE_BITS,
    parameter int PHASE_BITS       = $clog2(STEPS_PER_PERIOD)
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [PHASE_BITS-1:0]  i_rd_phase,
    input  logic [PHASE_BITS-1:0]  i_phase,
    input  twg_pkg::t_wave_mode    i_mode,
    input  logic [6:0]             i_duty,
    output logic [SAMPLE_BITS-1:0] o_sample
);

    localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
    localparam int SINE_SCALE = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int HALF       = STEPS_PER_PERIOD / 2;
    localparam int TRI_TOP    = 2 * HALF * twg_pkg::TRI_SLOPE;
    localparam int WW         = (PHASE_BITS + 7 > SAMPLE_BITS) ? PHASE_BITS + 7 : SAMPLE_BITS;
    localparam int DW         = (PHASE_BITS > 7) ? PHASE_BITS : 7;

    logic [SAMPLE_BITS-1:0] w_sine_rom [STEPS_PER_PERIOD];
    logic [SAMPLE_BITS-1:0] r_sine;

    logic [WW-1:0]          w_full;
    logic [WW-1:0]          w_tri_prod;
    logic [WW-1:0]          w_saw_prod;
    logic [WW-1:0]          w_tri_raw;
    logic                   w_rising;
    logic [SAMPLE_BITS-1:0] w_tri;
    logic [SAMPLE_BITS-1:0] w_saw;
    logic [SAMPLE_BITS-1:0] w_square;

    // The table is worked out while the design elaborates.
    for (genvar g = 0; g < STEPS_PER_PERIOD; g++) begin : g_sine
        localparam logic [63:0] ANGLE =
            (64'd628 * 64'(g) * twg_pkg::Q_ONE) / (64'd100 * 64'(STEPS_PER_PERIOD));
        localparam logic [63:0] CODE =
            twg_pkg::sine_code(ANGLE, 64'(SINE_SCALE), 64'(FULL_SCALE));
        assign w_sine_rom[g] = CODE[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sine <= w_sine_rom[i_rd_phase];
        end
    end

    always_comb begin
        w_full     = WW'(FULL_SCALE);
        w_tri_prod = WW'(i_phase) * WW'(twg_pkg::TRI_SLOPE);
        w_saw_prod = WW'(i_phase) * WW'(twg_pkg::SAW_SLOPE);
        w_rising   = ({1'b0, i_phase} <= (PHASE_BITS + 1)'(HALF));

        // The falling half bottoms out at zero instead of wrapping.
        if (w_rising) begin
            w_tri_raw = w_tri_prod;
        end else if (WW'(TRI_TOP) > w_tri_prod) begin
            w_tri_raw = WW'(TRI_TOP) - w_tri_prod;
        end else begin
            w_tri_raw = '0;
        end

        w_tri    = (w_tri_raw > w_full) ? w_full[SAMPLE_BITS-1:0] : w_tri_raw[SAMPLE_BITS-1:0];
        w_saw    = (w_saw_prod > w_full) ? w_full[SAMPLE_BITS-1:0] : w_saw_prod[SAMPLE_BITS-1:0];
        w_square = (DW'(i_phase) < DW'(i_duty)) ? w_full[SAMPLE_BITS-1:0] : '0;

        case (i_mode)
            twg_pkg::WAVE_SINE:     o_sample = r_sine;
            twg_pkg::WAVE_TRIANGLE: o_sample = w_tri;
            twg_pkg::WAVE_SAW:      o_sample = w_saw;
            default:                o_sample = w_square;
        endcase
    end

endmodule
